FILE: rtl/core/crtrs_pkg.sv
// crtrs_pkg: shared types and constants of the line-doubled crt raster sequencer
// holds the config, state and result structs and the register index codes
// no dependencies
package crtrs_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 15;
  localparam int AddrW    = 15;
  localparam int RowW     = 7;
  localparam int ScanW    = 5;
  localparam int LineW    = 10;

  localparam logic [CfgIdxW-1:0] REG_CHARS_PER_ROW   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VERTICAL_TOTAL  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VERTICAL_ADJUST = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ROWS_DISPLAYED  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_VSYNC_ROW       = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SCAN_FORMAT     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_CURSOR_ROWS     = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_START_ADDRESS   = 3'd7;

  // cursor blink mode codes, cursor_rows bits 6:5
  localparam logic [1:0] BLINK_FAST0 = 2'd0;
  localparam logic [1:0] BLINK_OFF   = 2'd1;
  localparam logic [1:0] BLINK_FAST2 = 2'd2;
  localparam logic [1:0] BLINK_SLOW  = 2'd3;

  typedef struct packed {
    logic [7:0]       chars_per_row;
    logic [RowW-1:0]  vertical_total;
    logic [4:0]       vertical_adjust;
    logic [RowW-1:0]  rows_displayed;
    logic [RowW-1:0]  vsync_row;
    logic [6:0]       scan_format;
    logic [11:0]      cursor_rows;
    logic [AddrW-1:0] start_address;
  } cfg_t;

  typedef struct packed {
    logic             half_phase;
    logic             double_flag;
    logic [ScanW-1:0] scan_count;
    logic [RowW-1:0]  row_count;
    logic [AddrW-1:0] mem_address;
    logic [AddrW-1:0] row_start_address;
    logic [4:0]       adjust_count;
    logic [4:0]       vsync_count;
    logic             display_on;
    logic             cursor_row_on;
    logic             cursor_blink_on;
    logic [7:0]       blink_counter;
    logic             field_parity;
    logic [LineW-1:0] line_counter;
    logic             stat_h;
    logic             stat_v;
  } state_t;

  typedef struct packed {
    logic             phase;
    logic             display_enable;
    logic [AddrW-1:0] row_address;
    logic [ScanW-1:0] render_row;
    logic [LineW-1:0] display_line;
    logic             hsync_status;
    logic             vsync_status;
    logic             cursor_visible;
    logic             frame_start;
    logic             line_double;
    logic [RowW-1:0]  char_row;
  } result_t;

  // scan row match, with the halved target also matching in interlace mode
  function automatic logic row_hit(input logic [ScanW-1:0] sc, input logic [ScanW-1:0] target,
                                   input logic il);
    row_hit = (sc == target) || (il && (sc == (target >> 1)));
  endfunction

endpackage

FILE: rtl/core/crtrs_step.sv
// crtrs_step: next-state and result logic for one half-line tick
// pure combinational, one pass per transaction
// depends on crtrs_pkg
module crtrs_step #(
  parameter int LINES_PER_FRAME_MAX = 720,
  parameter int VSYNC_LINES         = 16
) (
  input  crtrs_pkg::state_t  st,
  input  crtrs_pkg::cfg_t    cfg,
  input  logic               hold,
  output crtrs_pkg::state_t  st_nxt,
  output crtrs_pkg::result_t res
);
  import crtrs_pkg::*;

  localparam logic [LineW:0]   LineWrap  = (LineW+1)'(LINES_PER_FRAME_MAX);
  localparam logic [4:0]       VsyncLoad = 5'(VSYNC_LINES);

  logic             il;
  logic             four_color;
  logic [ScanW-1:0] max_scan;
  logic [ScanW-1:0] cur_start;
  logic [ScanW-1:0] cur_end;
  logic [LineW:0]   line_inc;
  logic [RowW-1:0]  old_row;
  logic             frame;
  logic [ScanW-1:0] render;
  state_t           s;

  assign il         = cfg.scan_format[5];
  assign four_color = cfg.scan_format[6];
  assign max_scan   = cfg.scan_format[4:0];
  assign cur_start  = cfg.cursor_rows[4:0];
  assign cur_end    = cfg.cursor_rows[11:7];
  assign line_inc   = {1'b0, st.line_counter} + (LineW+1)'(1);

  always_comb begin
    s       = st;
    frame   = 1'b0;
    old_row = st.row_count;
    render  = st.scan_count;
    if (hold) begin
      render = st.scan_count;
    end else if (!st.half_phase) begin
      // display half
      s.stat_h = 1'b1;
      render   = il ? {2'b00, st.scan_count[1:0], st.field_parity} : st.scan_count;
      if (st.display_on) begin
        s.mem_address = st.mem_address + AddrW'(cfg.chars_per_row);
      end
      if (st.row_count == cfg.vsync_row && st.scan_count == '0) begin
        s.stat_v = 1'b1;
      end
      s.line_counter = (line_inc >= LineWrap) ? '0 : line_inc[LineW-1:0];
      s.half_phase   = 1'b1;
    end else begin
      // retrace half
      s.half_phase = 1'b0;
      if (s.display_on) s.stat_h = 1'b0;
      s.double_flag = ~s.double_flag;
      if (s.double_flag && !four_color) begin
        // doubled line repeats the row
        s.mem_address = s.row_start_address;
      end else begin
        if (s.vsync_count != '0) begin
          s.vsync_count = s.vsync_count - 5'd1;
          if (s.vsync_count == '0) s.stat_v = 1'b0;
        end
        if (row_hit(s.scan_count, cur_end, il)) s.cursor_row_on = 1'b0;
        if (il && s.scan_count == (max_scan >> 1)) s.row_start_address = s.mem_address;

        priority if (s.adjust_count != '0) begin
          s.scan_count   = s.scan_count + ScanW'(1);
          s.mem_address  = s.row_start_address;
          s.adjust_count = s.adjust_count - 5'd1;
          if (s.adjust_count == '0) begin
            s.display_on        = 1'b1;
            s.mem_address       = cfg.start_address;
            s.row_start_address = cfg.start_address;
            s.scan_count        = '0;
          end
        end else if (row_hit(s.scan_count, max_scan, il)) begin
          old_row             = s.row_count;
          s.row_start_address = s.mem_address;
          s.scan_count        = '0;
          s.row_count         = s.row_count + RowW'(1);
          if (s.row_count == cfg.rows_displayed) s.display_on = 1'b0;
          if (old_row == cfg.vertical_total) begin
            s.row_count    = '0;
            s.adjust_count = cfg.vertical_adjust;
            if (cfg.vertical_adjust == '0) begin
              s.display_on        = 1'b1;
              s.mem_address       = cfg.start_address;
              s.row_start_address = cfg.start_address;
            end
            unique case (cfg.cursor_rows[6:5])
              BLINK_OFF:   s.cursor_blink_on = 1'b0;
              BLINK_SLOW:  s.cursor_blink_on = s.blink_counter[4];
              BLINK_FAST0: s.cursor_blink_on = s.blink_counter[3];
              BLINK_FAST2: s.cursor_blink_on = s.blink_counter[3];
              default:     s.cursor_blink_on = s.blink_counter[3];
            endcase
          end
          if (s.row_count == cfg.vsync_row) begin
            s.display_on    = 1'b0;
            s.line_counter  = '0;
            s.vsync_count   = VsyncLoad;
            s.blink_counter = s.blink_counter + 8'd1;
            s.field_parity  = ~s.field_parity;
            frame           = 1'b1;
          end
        end else begin
          s.scan_count  = s.scan_count + ScanW'(1);
          s.mem_address = s.row_start_address;
        end

        if (s.display_on) s.stat_h = 1'b0;
        if (row_hit(s.scan_count, cur_start, il)) s.cursor_row_on = 1'b1;
      end
      render = s.scan_count;
    end
  end

  assign st_nxt = s;

  always_comb begin
    res.phase          = hold ? ~st.half_phase : st.half_phase;
    res.display_enable = s.display_on;
    res.row_address    = s.mem_address;
    res.render_row     = render;
    res.display_line   = s.line_counter;
    res.hsync_status   = s.stat_h;
    res.vsync_status   = s.stat_v;
    res.cursor_visible = s.cursor_row_on & s.cursor_blink_on;
    res.frame_start    = frame;
    res.line_double    = s.double_flag;
    res.char_row       = s.row_count;
  end

endmodule

FILE: rtl/core/crt_raster_sequencer_line_doubled.sv
// crt_raster_sequencer_line_doubled: top level of the crt vertical timing sequencer
// config registers, sequencer state, result register; uses crtrs_step and crtrs_pkg
//
//   channel  signals                         direction  width
//   in       in_valid/in_ready, in_hold      in         1 payload bit
//   out      out_valid/out_ready, 11 fields  out        1..15 bits per field
//   cfg      cfg_we, cfg_index, cfg_wdata    in         3 index, 15 data
//
// every transaction loads state and the result register at the accepting edge, and the
// result is offered on the next cycle.
// a new transaction is taken each cycle while the result register is empty or drained.
// out_ready low stalls the input only while a result is waiting.
// rst_n (synchronous) clears the config registers, sequencer state and out_valid.
module crt_raster_sequencer_line_doubled #(
  parameter int LINES_PER_FRAME_MAX = 720,
  parameter int VSYNC_LINES         = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_hold,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_phase,
  output logic                                out_display_enable,
  output logic [crtrs_pkg::AddrW-1:0]         out_row_address,
  output logic [crtrs_pkg::ScanW-1:0]         out_render_row,
  output logic [crtrs_pkg::LineW-1:0]         out_display_line,
  output logic                                out_hsync_status,
  output logic                                out_vsync_status,
  output logic                                out_cursor_visible,
  output logic                                out_frame_start,
  output logic                                out_line_double,
  output logic [crtrs_pkg::RowW-1:0]          out_char_row,
  input  logic                                cfg_we,
  input  logic [crtrs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [crtrs_pkg::CfgDataW-1:0]      cfg_wdata
);
  import crtrs_pkg::*;

  cfg_t    cfg_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    out_valid_r;
  logic    in_fire;

  assign in_ready = ~out_valid_r | out_ready;
  assign in_fire  = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARS_PER_ROW:   cfg_r.chars_per_row   <= cfg_wdata[7:0];
        REG_VERTICAL_TOTAL:  cfg_r.vertical_total  <= cfg_wdata[RowW-1:0];
        REG_VERTICAL_ADJUST: cfg_r.vertical_adjust <= cfg_wdata[4:0];
        REG_ROWS_DISPLAYED:  cfg_r.rows_displayed  <= cfg_wdata[RowW-1:0];
        REG_VSYNC_ROW:       cfg_r.vsync_row       <= cfg_wdata[RowW-1:0];
        REG_SCAN_FORMAT:     cfg_r.scan_format     <= cfg_wdata[6:0];
        REG_CURSOR_ROWS:     cfg_r.cursor_rows     <= cfg_wdata[11:0];
        REG_START_ADDRESS:   cfg_r.start_address   <= cfg_wdata[AddrW-1:0];
        default:             cfg_r                 <= cfg_r;
      endcase
    end
  end

  crtrs_step #(
    .LINES_PER_FRAME_MAX(LINES_PER_FRAME_MAX),
    .VSYNC_LINES        (VSYNC_LINES)
  ) u_step (
    .st    (st_r),
    .cfg   (cfg_r),
    .hold  (in_hold),
    .st_nxt(st_nxt),
    .res   (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) res_r <= res_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_phase          = res_r.phase;
  assign out_display_enable = res_r.display_enable;
  assign out_row_address    = res_r.row_address;
  assign out_render_row     = res_r.render_row;
  assign out_display_line   = res_r.display_line;
  assign out_hsync_status   = res_r.hsync_status;
  assign out_vsync_status   = res_r.vsync_status;
  assign out_cursor_visible = res_r.cursor_visible;
  assign out_frame_start    = res_r.frame_start;
  assign out_line_double    = res_r.line_double;
  assign out_char_row       = res_r.char_row;

  // a held tick leaves the sequencer untouched
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_hold |=> $stable(st_r))
    else $error("held tick changed sequencer state");

  // a running tick alternates display and retrace halves
  a_half_toggle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !in_hold |=> st_r.half_phase != $past(st_r.half_phase))
    else $error("half phase did not toggle");

  // frame start only comes from a retrace half and restarts the line count
  a_frame_retrace: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.frame_start |-> res_r.phase && (res_r.display_line == '0))
    else $error("frame start outside retrace or line count not cleared");

  // line counter stays below the wrap point
  a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(st_r.line_counter) < LINES_PER_FRAME_MAX)
    else $error("line counter out of range");

endmodule
